FILE: rtl/core/sound_level_envelope_detector_unit_assert.svh
// Assertion macros for the sound level envelope detector.
`ifndef SOUND_LEVEL_ENVELOPE_DETECTOR_UNIT_ASSERT_SVH
`define SOUND_LEVEL_ENVELOPE_DETECTOR_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define SLED_ASSERT_NOW(lbl, clk, rst, ant, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ant) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset
`define SLED_ASSERT_NEXT(lbl, clk, rst, ant, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ant) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/sled_pkg.sv
package sled_pkg;

   // sample and level widths
   localparam int SAMPLE_BITS = 10;
   localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = 10'd1023;
   localparam int LEVEL_BITS = 3;
   localparam int MAX_LEVEL = 4;

   // level averaging ring
   localparam int AVG_DEPTH = 20;
   localparam int RING_ADDR_BITS = $clog2(AVG_DEPTH);
   localparam int TOTAL_BITS = $clog2(AVG_DEPTH * MAX_LEVEL + 1);

   // window counter
   localparam int WCNT_BITS = 16;
   localparam int WSAMP_BITS = 16;
   localparam int CMP_BITS = (WCNT_BITS + 1 > WSAMP_BITS + 1) ? WCNT_BITS + 1 : WSAMP_BITS + 1;
   localparam logic [CMP_BITS-1:0] COUNT_MAX = CMP_BITS'((64'd1 << WCNT_BITS) - 64'd1);

   // configuration port
   localparam int THRESH_BITS = 3;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS = 16;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WINDOW_SAMPLES = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HIGH_THRESHOLD = 2'd1;
   localparam logic [WSAMP_BITS-1:0] WINDOW_SAMPLES_RESET = 16'd50;

   // closed-window level word between tracker and ring
   typedef struct packed {
      logic                  valid;
      logic [LEVEL_BITS-1:0] level;
   } lvl_word_type;

   // total / AVG_DEPTH as a set of independent threshold compares
   function automatic logic [LEVEL_BITS-1:0] average_of(input logic [TOTAL_BITS-1:0] total);
      logic [LEVEL_BITS-1:0] avg;
      avg = '0;
      for (int k = 1; k <= MAX_LEVEL; k++) begin
         if (total >= TOTAL_BITS'(k * AVG_DEPTH)) begin
            avg = LEVEL_BITS'(k);
         end
      end
      return avg;
   endfunction

endpackage

FILE: rtl/core/sound_level_envelope_detector_unit.sv
// Sound level envelope detector. Takes one 10-bit microphone sample per
// cycle while not stalled and tracks its maximum and minimum over a window
// of window_samples samples (0 counts as 1). The closing sample of a window
// produces one result word: the window's peak-to-peak span in whole volts
// (0..4), the truncated mean of the last 20 such levels, and a flag set
// when that mean exceeds high_threshold. A result passes through the level
// word register and then the result register; the level ring memory takes
// a single read-modify-write per level, its next entry prefetched into a
// read register. The ring reads as zero after reset through per-entry valid
// bits, so there is no clearing pass. The sample side stalls only when a
// closed level and the result register are both held by a stalled result.
module sound_level_envelope_detector_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   // sample channel
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [sled_pkg::SAMPLE_BITS-1:0]      req_adc_sample,
   // result channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [sled_pkg::LEVEL_BITS-1:0]       rsp_window_level,
   output logic [sled_pkg::LEVEL_BITS-1:0]       rsp_average_level,
   output logic                                  rsp_sound_high,
   // configuration writes
   input  logic                                  csr_write,
   input  logic [sled_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [sled_pkg::CSR_DATA_BITS-1:0]    csr_data
);

`include "sound_level_envelope_detector_unit_assert.svh"

   logic [sled_pkg::WSAMP_BITS-1:0]  window_samples_ff;
   logic [sled_pkg::THRESH_BITS-1:0] high_threshold_ff;

   sled_pkg::lvl_word_type           lvl_word;
   logic                             ring_ready;

   // configuration registers; other indexes are ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         window_samples_ff <= sled_pkg::WINDOW_SAMPLES_RESET;
         high_threshold_ff <= '0;
      end else if (csr_write) begin
         if (csr_index == sled_pkg::CSR_WINDOW_SAMPLES) begin
            window_samples_ff <= csr_data[sled_pkg::WSAMP_BITS-1:0];
         end else if (csr_index == sled_pkg::CSR_HIGH_THRESHOLD) begin
            high_threshold_ff <= csr_data[sled_pkg::THRESH_BITS-1:0];
         end
      end
   end

   // window tracker
   sled_window u_window (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_adc_sample (req_adc_sample),
      .window_samples (window_samples_ff),
      .ring_ready     (ring_ready),
      .lvl_word       (lvl_word)
   );

   // level ring and result register
   sled_ring u_ring (
      .clock             (clock),
      .reset             (reset),
      .lvl_word          (lvl_word),
      .ring_ready        (ring_ready),
      .high_threshold    (high_threshold_ff),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_window_level  (rsp_window_level),
      .rsp_average_level (rsp_average_level),
      .rsp_sound_high    (rsp_sound_high)
   );

   // checks
   `SLED_ASSERT_NOW(a_level_range, clock, reset, rsp_valid, (rsp_window_level <= 3'd4) && (rsp_average_level <= 3'd4), "result level out of range")
   `SLED_ASSERT_NOW(a_stall_cause, clock, reset, req_stall, lvl_word.valid && rsp_valid && rsp_stall, "sample stall without a held level")
   `SLED_ASSERT_NEXT(a_no_phantom, clock, reset, (!rsp_valid || !rsp_stall) && !lvl_word.valid, !rsp_valid, "result without a closed window")

endmodule

FILE: rtl/core/sled_window.sv
module sled_window (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [sled_pkg::SAMPLE_BITS-1:0]    req_adc_sample,
   input  logic [sled_pkg::WSAMP_BITS-1:0]     window_samples,
   input  logic                                ring_ready,
   output sled_pkg::lvl_word_type              lvl_word
);

   logic [sled_pkg::SAMPLE_BITS-1:0] max_ff, max_in;
   logic [sled_pkg::SAMPLE_BITS-1:0] min_ff, min_in;
   logic [sled_pkg::WCNT_BITS-1:0]   count_ff, count_in;
   sled_pkg::lvl_word_type           lvl_ff, lvl_in;

   logic                             advance;
   logic                             accept;
   logic                             close;
   logic [sled_pkg::SAMPLE_BITS-1:0] new_max, new_min, span;
   logic [sled_pkg::SAMPLE_BITS+2:0] scaled;
   logic [sled_pkg::CMP_BITS-1:0]    next_count, target;

   // level word moves on when empty or taken by the ring
   assign advance   = !lvl_ff.valid || ring_ready;
   assign req_stall = !advance;
   assign accept    = req_valid && advance;

   // running extremes including this sample, updated independently
   assign new_max = (req_adc_sample > max_ff) ? req_adc_sample : max_ff;
   assign new_min = (req_adc_sample < min_ff) ? req_adc_sample : min_ff;

   // window end: target reached or counter saturated; zero acts as one
   assign next_count = sled_pkg::CMP_BITS'(count_ff) + sled_pkg::CMP_BITS'(1);
   assign target     = (window_samples == '0) ? sled_pkg::CMP_BITS'(1)
                                              : sled_pkg::CMP_BITS'(window_samples);
   assign close      = (next_count >= target) || (next_count >= sled_pkg::COUNT_MAX);

   // floor(span * 5 / 1024)
   assign span   = (new_max >= new_min) ? (new_max - new_min) : '0;
   assign scaled = ({3'b000, span} << 2) + {3'b000, span};

   always_comb begin
      max_in   = max_ff;
      min_in   = min_ff;
      count_in = count_ff;
      lvl_in   = lvl_ff;
      if (advance) begin
         lvl_in.valid = 1'b0;
      end
      if (accept) begin
         if (close) begin
            max_in       = '0;
            min_in       = sled_pkg::SAMPLE_MAX;
            count_in     = '0;
            lvl_in.valid = 1'b1;
            lvl_in.level = scaled[sled_pkg::SAMPLE_BITS+2:sled_pkg::SAMPLE_BITS];
         end else begin
            max_in   = new_max;
            min_in   = new_min;
            count_in = next_count[sled_pkg::WCNT_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff       <= '0;
         min_ff       <= sled_pkg::SAMPLE_MAX;
         count_ff     <= '0;
         lvl_ff.valid <= 1'b0;
      end else begin
         max_ff       <= max_in;
         min_ff       <= min_in;
         count_ff     <= count_in;
         lvl_ff.valid <= lvl_in.valid;
      end
      // level payload needs no reset
      lvl_ff.level <= lvl_in.level;
   end

   assign lvl_word = lvl_ff;

endmodule

FILE: rtl/core/sled_ring.sv
module sled_ring (
   input  logic                                clock,
   input  logic                                reset,
   input  sled_pkg::lvl_word_type              lvl_word,
   output logic                                ring_ready,
   input  logic [sled_pkg::THRESH_BITS-1:0]    high_threshold,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [sled_pkg::LEVEL_BITS-1:0]     rsp_window_level,
   output logic [sled_pkg::LEVEL_BITS-1:0]     rsp_average_level,
   output logic                                rsp_sound_high
);

   // level ring memory, one write and one registered read per cycle
   logic [sled_pkg::LEVEL_BITS-1:0]     ring_mem [sled_pkg::AVG_DEPTH];
   logic [sled_pkg::AVG_DEPTH-1:0]      entry_valid_ff, entry_valid_in;
   logic [sled_pkg::LEVEL_BITS-1:0]     rd_data_ff;
   logic                                rd_valid_ff;

   logic [sled_pkg::RING_ADDR_BITS-1:0] pos_ff, pos_in, pos_wrap;
   logic [sled_pkg::TOTAL_BITS-1:0]     total_ff, total_in;

   logic                                rsp_valid_ff, rsp_valid_in;
   logic [sled_pkg::LEVEL_BITS-1:0]     window_level_ff, window_level_in;
   logic [sled_pkg::LEVEL_BITS-1:0]     average_level_ff, average_level_in;
   logic                                sound_high_ff, sound_high_in;

   logic                                take;
   logic [sled_pkg::LEVEL_BITS-1:0]     old_level;
   logic [sled_pkg::LEVEL_BITS-1:0]     avg;

   // output word register frees up when empty or delivered
   assign ring_ready = !(rsp_valid_ff && rsp_stall);
   assign take       = lvl_word.valid && ring_ready;

   // read data was prefetched for the current position; unwritten entries read zero
   assign old_level = rd_valid_ff ? rd_data_ff : '0;

   assign pos_wrap = (pos_ff == sled_pkg::RING_ADDR_BITS'(sled_pkg::AVG_DEPTH - 1))
                     ? '0 : pos_ff + sled_pkg::RING_ADDR_BITS'(1);

   always_comb begin
      pos_in         = pos_ff;
      total_in       = total_ff;
      entry_valid_in = entry_valid_ff;
      if (take) begin
         pos_in                 = pos_wrap;
         total_in               = total_ff - sled_pkg::TOTAL_BITS'(old_level)
                                  + sled_pkg::TOTAL_BITS'(lvl_word.level);
         entry_valid_in[pos_ff] = 1'b1;
      end
   end

   assign avg = sled_pkg::average_of(total_in);

   // output word
   always_comb begin
      rsp_valid_in     = rsp_valid_ff;
      window_level_in  = window_level_ff;
      average_level_in = average_level_ff;
      sound_high_in    = sound_high_ff;
      if (ring_ready) begin
         rsp_valid_in     = take;
         window_level_in  = lvl_word.level;
         average_level_in = avg;
         sound_high_in    = (sled_pkg::THRESH_BITS'(avg) > high_threshold);
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff         <= '0;
         total_ff       <= '0;
         entry_valid_ff <= '0;
         rd_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         pos_ff         <= pos_in;
         total_ff       <= total_in;
         entry_valid_ff <= entry_valid_in;
         rd_valid_ff    <= entry_valid_ff[pos_in];
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // memory write at the current slot, read one slot ahead
   always_ff @(posedge clock) begin
      if (take) begin
         ring_mem[pos_ff] <= lvl_word.level;
      end
      rd_data_ff <= ring_mem[pos_in];
   end

   // output payload
   always_ff @(posedge clock) begin
      window_level_ff  <= window_level_in;
      average_level_ff <= average_level_in;
      sound_high_ff    <= sound_high_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_window_level  = window_level_ff;
   assign rsp_average_level = average_level_ff;
   assign rsp_sound_high    = sound_high_ff;

endmodule

FILE: dv/sound_level_envelope_detector_unit_tb.sv
`timescale 1ns / 100ps

module sound_level_envelope_detector_unit_tb;
   import sled_pkg::*;

   localparam int COUNT_BITS = WCNT_BITS + 1;
   localparam int SETTLE_CYCLES = 6;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int PHASE_ITEMS = 35;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_HI = 2'd3;

   typedef enum int {TONE_LOUD, TONE_QUIET, TONE_ANY} tone_type;

   // one expected result word
   typedef struct {
      logic [LEVEL_BITS-1:0] window_level;
      logic [LEVEL_BITS-1:0] average_level;
      logic                  sound_high;
   } level_word_type;

   // envelope predictor plus the queue of levels it still expects
   class level_scoreboard;
      logic [WSAMP_BITS-1:0]  win_samples;
      logic [THRESH_BITS-1:0] thresh;
      logic [SAMPLE_BITS-1:0] peak_hi;
      logic [SAMPLE_BITS-1:0] peak_lo;
      logic [COUNT_BITS-1:0]  win_count;
      logic [LEVEL_BITS-1:0]  ring [AVG_DEPTH];
      int unsigned            ring_pos;
      logic [TOTAL_BITS-1:0]  total;
      level_word_type         expected_levels [$];
      int errors;
      int samples_seen;
      int results_seen;
      int flag_windows;
      int top_average;
      logic [MAX_LEVEL:0]     levels_seen;

      function new();
         win_samples = WINDOW_SAMPLES_RESET;
         thresh = '0;
         peak_hi = '0;
         peak_lo = SAMPLE_MAX;
         win_count = '0;
         foreach (ring[i]) ring[i] = '0;
         ring_pos = 0;
         total = '0;
         errors = 0;
         samples_seen = 0;
         results_seen = 0;
         flag_windows = 0;
         top_average = 0;
         levels_seen = '0;
      endfunction

      function int pending();
         return expected_levels.size();
      endfunction

      // indexes past the two registers are dropped
      function void write_reg(logic [CSR_INDEX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] data);
         if (idx == CSR_WINDOW_SAMPLES) begin
            win_samples = data[WSAMP_BITS-1:0];
         end else if (idx == CSR_HIGH_THRESHOLD) begin
            thresh = data[THRESH_BITS-1:0];
         end
      endfunction

      function void note_sample(logic [SAMPLE_BITS-1:0] s);
         logic [COUNT_BITS-1:0]  target;
         logic [COUNT_BITS-1:0]  next_count;
         logic [COUNT_BITS-1:0]  count_top;
         logic [SAMPLE_BITS-1:0] span;
         logic [12:0]            scaled;
         logic [LEVEL_BITS-1:0]  lvl;
         logic [LEVEL_BITS-1:0]  avg;
         level_word_type         word;
         samples_seen++;
         // max and min track independently
         if (s > peak_hi) peak_hi = s;
         if (s < peak_lo) peak_lo = s;
         // zero window acts as one; counter saturates at its top value
         target = (win_samples == '0) ? COUNT_BITS'(1) : COUNT_BITS'(win_samples);
         count_top = COUNT_BITS'((64'd1 << WCNT_BITS) - 64'd1);
         next_count = win_count + 1'b1;
         if (next_count < target && next_count < count_top) begin
            win_count = next_count;
            return;
         end
         // close the window: span to whole volts, floor(span * 5 / 1024)
         span = (peak_hi >= peak_lo) ? peak_hi - peak_lo : '0;
         scaled = 13'(span) * 13'd5;
         lvl = scaled[12:10];
         if (ring_pos >= AVG_DEPTH) ring_pos = 0;
         total = total - TOTAL_BITS'(ring[ring_pos]) + TOTAL_BITS'(lvl);
         ring[ring_pos] = lvl;
         ring_pos = (ring_pos + 1 >= AVG_DEPTH) ? 0 : ring_pos + 1;
         avg = LEVEL_BITS'(total / AVG_DEPTH);
         word.window_level = lvl;
         word.average_level = avg;
         word.sound_high = (avg > thresh);
         expected_levels.push_back(word);
         peak_hi = '0;
         peak_lo = SAMPLE_MAX;
         win_count = '0;
      endfunction

      task report_mismatch(string what);
         $display("%0t ns mismatch: %s", $time, what);
         errors++;
      endtask

      task check_result(logic [LEVEL_BITS-1:0] lvl, logic [LEVEL_BITS-1:0] avg, logic flag);
         level_word_type want;
         results_seen++;
         if (expected_levels.size() == 0) begin
            report_mismatch($sformatf("unexpected word level=%0d avg=%0d high=%0d",
                                      lvl, avg, flag));
            return;
         end
         want = expected_levels.pop_front();
         if (lvl !== want.window_level)
            report_mismatch($sformatf("window_level got %0d want %0d", lvl, want.window_level));
         if (avg !== want.average_level)
            report_mismatch($sformatf("average_level got %0d want %0d", avg,
                                      want.average_level));
         if (flag !== want.sound_high)
            report_mismatch($sformatf("sound_high got %0d want %0d", flag, want.sound_high));
         levels_seen[want.window_level] = 1'b1;
         if (int'(want.average_level) > top_average) top_average = int'(want.average_level);
         if (want.sound_high) flag_windows++;
      endtask
   endclass

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   logic [SAMPLE_BITS-1:0]    req_adc_sample;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic [LEVEL_BITS-1:0]     rsp_window_level;
   logic [LEVEL_BITS-1:0]     rsp_average_level;
   logic                      rsp_sound_high;
   logic                      csr_write;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_data;

   level_scoreboard sb = new();
   int send_idle_pct;
   int rsp_stall_pct;
   int idle_cycles = 0;
   int settings_used;

   sound_level_envelope_detector_unit dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_adc_sample    (req_adc_sample),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_window_level  (rsp_window_level),
      .rsp_average_level (rsp_average_level),
      .rsp_sound_high    (rsp_sound_high),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // receiver back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   // monitors on both channels and the no-progress watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_sample(req_adc_sample);
         if (rsp_valid && !rsp_stall)
            sb.check_result(rsp_window_level, rsp_average_level, rsp_sound_high);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t ns timeout: no word moved for %0d cycles", $time, idle_cycles);
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   function automatic void set_idling(int mode);
      case (mode)
         0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
         1: begin send_idle_pct = 68; rsp_stall_pct = 0;  end
         2: begin send_idle_pct = 0;  rsp_stall_pct = 68; end
         default: begin send_idle_pct = 37; rsp_stall_pct = 37; end
      endcase
   endfunction

   function automatic logic [SAMPLE_BITS-1:0] pick_sample(tone_type tone, int pos);
      int base;
      case (tone)
         // alternate near the rails so every window has a wide span
         TONE_LOUD: begin
            if (pos % 2 == 0) return SAMPLE_BITS'($urandom_range(0, 40));
            return SAMPLE_BITS'(1023 - $urandom_range(0, 40));
         end
         TONE_QUIET: begin
            base = $urandom_range(100, 923);
            return SAMPLE_BITS'(base + $urandom_range(0, 100) - 50);
         end
         default: return SAMPLE_BITS'($urandom_range(0, 1023));
      endcase
   endfunction

   // hold one sample word until it is taken
   task automatic send_sample(logic [SAMPLE_BITS-1:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_adc_sample <= value;
      do @(posedge clock); while (!(req_valid && !req_stall));
   endtask

   // stop sending, let every expected word drain, then let the pipe empty
   task automatic settle_block();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_INDEX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] data);
      settle_block();
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      sb.write_reg(idx, data);
      csr_write <= 1'b0;
      settings_used++;
   endtask

   initial begin
      tone_type tone;
      int    win;
      int    in_window;
      logic [THRESH_BITS-1:0] thr;
      reset = 1'b1;
      req_valid = 1'b0;
      req_adc_sample = '0;
      csr_write = 1'b0;
      csr_index = '0;
      csr_data = '0;
      settings_used = 1;
      set_idling(0);
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset-value registers: two 50-sample windows, threshold zero
      for (int n = 0; n < 100; n++) send_sample(pick_sample(TONE_LOUD, n));

      // span edges with two-sample windows: full scale, 204/205, 819/820, flat
      write_csr(CSR_WINDOW_SAMPLES, 16'd2);
      write_csr(CSR_HIGH_THRESHOLD, 16'd0);
      send_sample(10'd0);    send_sample(10'd1023);
      send_sample(10'd1023); send_sample(10'd0);
      send_sample(10'd0);    send_sample(10'd204);
      send_sample(10'd0);    send_sample(10'd205);
      send_sample(10'd819);  send_sample(10'd0);
      send_sample(10'd820);  send_sample(10'd0);
      send_sample(10'd512);  send_sample(10'd512);
      send_sample(10'd1023); send_sample(10'd1023);

      // zero window closes on every sample, as does a window of one
      write_csr(CSR_WINDOW_SAMPLES, 16'd0);
      send_sample(10'd0); send_sample(10'd1023); send_sample(10'd511);
      write_csr(CSR_WINDOW_SAMPLES, 16'd1);
      send_sample(10'd1023); send_sample(10'd0);

      // spare indexes must not disturb either register
      write_csr(CSR_SPARE_LO, 16'(($urandom_range(0, 65535))));
      write_csr(CSR_SPARE_HI, 16'hFFFF);
      send_sample(10'd700); send_sample(10'd3);

      // longest window with junk above the threshold bits (threshold 7), then a
      // short window closes the partly filled one on the next sample
      write_csr(CSR_WINDOW_SAMPLES, 16'hFFFF);
      write_csr(CSR_HIGH_THRESHOLD, 16'hFFFF);
      for (int n = 0; n < 20; n++) send_sample(pick_sample(TONE_ANY, n));
      write_csr(CSR_WINDOW_SAMPLES, 16'd3);
      send_sample(10'd1); send_sample(10'd1000);

      // random phases across idling modes and settings
      tone = TONE_LOUD;
      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            4: win = 1;
            6: win = 0;
            default: win = $urandom_range(2, 6);
         endcase
         case (ph)
            0: thr = 3'd0;
            1: thr = 3'd1;
            2: thr = 3'd2;
            3: thr = 3'd3;
            4: thr = 3'd4;
            5: thr = 3'd7;
            6: thr = 3'd2;
            default: thr = 3'(($urandom_range(0, 7)));
         endcase
         write_csr(CSR_WINDOW_SAMPLES, 16'(win));
         write_csr(CSR_HIGH_THRESHOLD, {13'(($urandom_range(0, 8191))), thr});
         set_idling(ph % 4);
         in_window = 0;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (in_window == 0 && $urandom_range(15) == 0)
               tone = tone_type'($urandom_range(0, 2));
            send_sample(pick_sample(tone, in_window));
            in_window = (in_window + 1 >= win) ? 0 : in_window + 1;
            // sender holds off until everything owed has come back
            if (ph % 4 == 1 && n == PHASE_ITEMS / 2) settle_block();
         end
      end

      // drain and finish
      settle_block();
      repeat (10) @(posedge clock);
      while (sb.pending() != 0) begin
         sb.report_mismatch("expected word never arrived");
         void'(sb.expected_levels.pop_front());
      end
      $display("Summary: %0d samples, %0d result words under %0d register settings",
               sb.samples_seen, sb.results_seen, settings_used);
      $display("Summary: levels seen %b (bit n = level n), top average %0d, %0d flagged",
               sb.levels_seen, sb.top_average, sb.flag_windows);
      if (sb.errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
